// File: rtl/core/dfs_pkg.sv
package dfs_pkg;

    localparam int DFS_MAX_ENTRIES = 64;
    localparam int DFS_COORD_BITS  = 16;

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_FOCUS = 2'd2;
    localparam logic [1:0] CMD_MOVE  = 2'd3;

    // direction codes
    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_UP    = 3'd1;
    localparam logic [2:0] DIR_DOWN  = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_RIGHT = 3'd4;

    // configuration register indexes (paddr[2])
    localparam logic REG_WRAP_ENABLE = 1'b0;
    localparam logic REG_PERP_WEIGHT = 1'b1;

    localparam logic [3:0] PERP_WEIGHT_RESET = 4'd2;

    typedef enum logic [1:0] {
        SCAN_LOOKUP = 2'd0,
        SCAN_SEARCH = 2'd1,
        SCAN_WRAP   = 2'd2
    } dfs_scan_mode_t;

    // controller -> datapath
    typedef struct packed {
        logic           accept;
        logic           scan_start;
        dfs_scan_mode_t scan_mode;
        logic           snap;
        logic           commit;
    } dfs_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic move_go;
        logic scan_done;
        logic found;
        logic dir_ok;
        logic have_best;
    } dfs_status_t;

endpackage

// File: rtl/core/dfs_ctrl.sv
module dfs_ctrl
    import dfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        wrap_enable,
    input  dfs_status_t stat,
    output dfs_ctl_t    ctl,
    output logic        busy,
    output logic        done
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_WRAP   = 5'b01000,
        ST_RESP   = 5'b10000
    } dfs_state_t;

    dfs_state_t state_reg;
    dfs_state_t state_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.accept = 1'b1;
                    if (stat.move_go)
                    begin
                        ctl.scan_start = 1'b1;
                        ctl.scan_mode  = SCAN_LOOKUP;
                        state_next     = ST_LOOKUP;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_LOOKUP:
            begin
                if (stat.scan_done)
                begin
                    if (!stat.found)
                    begin
                        ctl.snap   = 1'b1;
                        state_next = ST_RESP;
                    end
                    else if (!stat.dir_ok)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        ctl.scan_start = 1'b1;
                        ctl.scan_mode  = SCAN_SEARCH;
                        state_next     = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (stat.scan_done)
                begin
                    if (stat.have_best)
                    begin
                        ctl.commit = 1'b1;
                        state_next = ST_RESP;
                    end
                    else if (wrap_enable)
                    begin
                        ctl.scan_start = 1'b1;
                        ctl.scan_mode  = SCAN_WRAP;
                        state_next     = ST_WRAP;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_WRAP:
            begin
                if (stat.scan_done)
                begin
                    ctl.commit = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_RESP);

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block not idle after result transfer");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register lost its one-hot code");
`endif

endmodule

// File: rtl/core/dfs_dp.sv
module dfs_dp
    import dfs_pkg::*;
#(
    parameter int MAX_ENTRIES = DFS_MAX_ENTRIES,
    parameter int COORD_BITS  = DFS_COORD_BITS,
    localparam int CW = $clog2(MAX_ENTRIES + 1),
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dfs_ctl_t                     ctl,
    output dfs_status_t                  stat,
    input  logic [1:0]                   cmd,
    input  logic [31:0]                  elem_id,
    input  logic signed [COORD_BITS-1:0] box_x,
    input  logic signed [COORD_BITS-1:0] box_y,
    input  logic [COORD_BITS-1:0]        box_w,
    input  logic [COORD_BITS-1:0]        box_h,
    input  logic [2:0]                   dir,
    input  logic [3:0]                   perp_weight,
    output logic [31:0]                  focused_id,
    output logic                         focus_valid,
    output logic                         focus_changed,
    output logic [CW-1:0]                entries_used
);

    localparam int XW  = COORD_BITS + 2;  // doubled centre
    localparam int DW  = COORD_BITS + 3;  // centre difference / magnitude
    localparam int PW  = COORD_BITS + 4;  // primary distance
    localparam int PRW = COORD_BITS + 7;  // weighted perpendicular offset
    localparam int SW  = COORD_BITS + 8;  // score

    // entry table
    logic [31:0]          ids_mem [MAX_ENTRIES];
    logic signed [XW-1:0] cx_mem  [MAX_ENTRIES];
    logic signed [XW-1:0] cy_mem  [MAX_ENTRIES];

    logic [CW-1:0]        count_reg;
    logic [31:0]          focus_id_reg;
    logic                 focus_held_reg;
    logic [31:0]          old_id_reg;
    logic                 old_held_reg;
    logic [2:0]           dir_reg;

    // scan control
    logic                 scan_active_reg;
    logic [CW-1:0]        scan_cnt_reg;
    dfs_scan_mode_t       scan_mode_reg;
    logic                 s1_v_reg;
    logic                 s2_v_reg;
    logic                 found_reg;
    logic                 have_best_reg;

    // scan payload
    logic [31:0]          rd_id_reg;
    logic signed [XW-1:0] rd_cx_reg;
    logic signed [XW-1:0] rd_cy_reg;
    logic                 s1_first_reg;
    logic signed [XW-1:0] fx_reg;
    logic signed [XW-1:0] fy_reg;
    logic [31:0]          first_id_reg;
    logic [31:0]          s2_id_reg;
    logic signed [PW-1:0] s2_prim_reg;
    logic [DW-1:0]        s2_perp_reg;
    logic                 s2_ok_reg;
    logic [31:0]          best_id_reg;
    logic signed [SW-1:0] low_score_reg;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [XW-1:0] add_cx;
    logic signed [XW-1:0] add_cy;
    logic                 issue;
    logic [AW-1:0]        rd_addr;
    logic                 is_focus;
    logic                 wrap_mode;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DW-1:0]        adx;
    logic [DW-1:0]        ady;
    logic signed [PW-1:0] dx_ext;
    logic signed [PW-1:0] dy_ext;
    logic signed [PW-1:0] cx_ext;
    logic signed [PW-1:0] cy_ext;
    logic signed [PW-1:0] prim;
    logic [DW-1:0]        perp;
    logic                 ok;
    logic [PRW-1:0]       prod;
    logic signed [SW-1:0] prod_s;
    logic signed [SW-1:0] prim_s;
    logic signed [SW-1:0] score;
    logic                 better;
    logic                 scan_done;

    assign wr_en   = ctl.accept && (cmd == CMD_ADD) && (count_reg < CW'(MAX_ENTRIES));
    assign wr_addr = count_reg[AW-1:0];
    assign add_cx  = $signed({box_x[COORD_BITS-1], box_x, 1'b0}) + $signed({2'b00, box_w});
    assign add_cy  = $signed({box_y[COORD_BITS-1], box_y, 1'b0}) + $signed({2'b00, box_h});

    assign issue   = scan_active_reg && (scan_cnt_reg < count_reg);
    assign rd_addr = scan_cnt_reg[AW-1:0];

    assign scan_done = scan_active_reg && !issue && !s1_v_reg && !s2_v_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ids_mem[wr_addr] <= elem_id;
            cx_mem[wr_addr]  <= add_cx;
            cy_mem[wr_addr]  <= add_cy;
        end
        if (issue)
        begin
            rd_id_reg <= ids_mem[rd_addr];
            rd_cx_reg <= cx_mem[rd_addr];
            rd_cy_reg <= cy_mem[rd_addr];
        end
    end

    // score a candidate from the registered read
    assign is_focus  = (rd_id_reg == focus_id_reg);
    assign wrap_mode = (scan_mode_reg == SCAN_WRAP);
    assign dx        = rd_cx_reg - fx_reg;
    assign dy        = rd_cy_reg - fy_reg;
    assign adx       = dx[DW-1] ? -dx : dx;
    assign ady       = dy[DW-1] ? -dy : dy;
    assign dx_ext    = dx;
    assign dy_ext    = dy;
    assign cx_ext    = rd_cx_reg;
    assign cy_ext    = rd_cy_reg;

    always_comb
    begin
        unique case (dir_reg)
            DIR_UP:
            begin
                prim = wrap_mode ? -cy_ext : -dy_ext;
                perp = adx;
            end
            DIR_DOWN:
            begin
                prim = wrap_mode ? cy_ext : dy_ext;
                perp = adx;
            end
            DIR_LEFT:
            begin
                prim = wrap_mode ? -cx_ext : -dx_ext;
                perp = ady;
            end
            default:
            begin
                prim = wrap_mode ? cx_ext : dx_ext;
                perp = ady;
            end
        endcase
    end

    assign ok = !is_focus && (wrap_mode || (prim > $signed(PW'(1))));

    assign prod   = PRW'(s2_perp_reg) * PRW'(perp_weight);
    assign prod_s = $signed({1'b0, prod});
    assign prim_s = s2_prim_reg;
    assign score  = prim_s + prod_s;
    assign better = s2_v_reg && s2_ok_reg && (!have_best_reg || (score < low_score_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            focus_id_reg    <= '0;
            focus_held_reg  <= 1'b0;
            scan_active_reg <= 1'b0;
            scan_cnt_reg    <= '0;
            scan_mode_reg   <= SCAN_LOOKUP;
            s1_v_reg        <= 1'b0;
            s2_v_reg        <= 1'b0;
            found_reg       <= 1'b0;
            have_best_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.accept)
            begin
                unique case (cmd)
                    CMD_CLEAR:
                    begin
                        count_reg <= '0;
                    end
                    CMD_ADD:
                    begin
                        if (wr_en)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (!focus_held_reg)
                        begin
                            focus_id_reg   <= elem_id;
                            focus_held_reg <= 1'b1;
                        end
                    end
                    CMD_FOCUS:
                    begin
                        focus_id_reg   <= elem_id;
                        focus_held_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (ctl.snap)
            begin
                focus_id_reg   <= first_id_reg;
                focus_held_reg <= 1'b1;
            end
            else if (ctl.commit && have_best_reg)
            begin
                focus_id_reg   <= best_id_reg;
                focus_held_reg <= 1'b1;
            end

            // advance the read pipeline
            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg && (scan_mode_reg != SCAN_LOOKUP);

            if (ctl.scan_start)
            begin
                scan_active_reg <= 1'b1;
                scan_cnt_reg    <= '0;
                scan_mode_reg   <= ctl.scan_mode;
                have_best_reg   <= 1'b0;
                if (ctl.scan_mode == SCAN_LOOKUP)
                begin
                    found_reg <= 1'b0;
                end
            end
            else
            begin
                if (scan_done)
                begin
                    scan_active_reg <= 1'b0;
                end
                if (issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (s1_v_reg && (scan_mode_reg == SCAN_LOOKUP) && focus_held_reg
                    && is_focus)
                begin
                    found_reg <= 1'b1;
                end
                if (better)
                begin
                    have_best_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            old_id_reg   <= focus_id_reg;
            old_held_reg <= focus_held_reg;
            dir_reg      <= dir;
        end
        s1_first_reg <= (scan_cnt_reg == '0);
        if (s1_v_reg && (scan_mode_reg == SCAN_LOOKUP))
        begin
            if (s1_first_reg)
            begin
                first_id_reg <= rd_id_reg;
            end
            if (focus_held_reg && is_focus && !found_reg)
            begin
                fx_reg <= rd_cx_reg;
                fy_reg <= rd_cy_reg;
            end
        end
        s2_id_reg   <= rd_id_reg;
        s2_prim_reg <= prim;
        s2_perp_reg <= perp;
        s2_ok_reg   <= ok;
        if (better)
        begin
            best_id_reg   <= s2_id_reg;
            low_score_reg <= score;
        end
    end

    assign stat.move_go   = (cmd == CMD_MOVE) && (dir != DIR_NONE) && (count_reg != '0);
    assign stat.scan_done = scan_done;
    assign stat.found     = found_reg;
    assign stat.dir_ok    = (dir_reg <= DIR_RIGHT);
    assign stat.have_best = have_best_reg;

    assign focused_id    = focus_id_reg;
    assign focus_valid   = focus_held_reg;
    assign focus_changed = focus_held_reg && (!old_held_reg || (focus_id_reg != old_id_reg));
    assign entries_used  = count_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table depth");
`endif

endmodule

// File: rtl/core/directional_focus_search.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------------
// command  | start, busy            | cmd, elem_id, box_x, box_y, box_w, box_h, dir
// result   | done (one-cycle strobe)| focused_id, focus_valid, focus_changed,
//          |                        | entries_used
// config   | psel, penable, pwrite, | paddr, pwdata, prdata (wrap_enable at 0x0,
//          | pready (tied high)     | perp_weight at 0x4)
//
// Clear, add and set-focus step from accept straight to the result strobe.
// A move runs a lookup pass for the focused entry, then a scoring pass and an
// optional wrap pass, each reading the entry table through its single read port
// (one entry per cycle).
// Reset (rst_n low, asynchronous) empties the table and drops focus; the table
// contents themselves are not cleared and need no clearing pass.
// One transfer is in flight at a time; busy stays high through the result strobe.
// The receiver cannot stall: each result is valid for the strobe cycle only.
module directional_focus_search
    import dfs_pkg::*;
#(
    parameter int MAX_ENTRIES = DFS_MAX_ENTRIES,
    parameter int COORD_BITS  = DFS_COORD_BITS,
    localparam int CW = $clog2(MAX_ENTRIES + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   cmd,
    input  logic [31:0]                  elem_id,
    input  logic signed [COORD_BITS-1:0] box_x,
    input  logic signed [COORD_BITS-1:0] box_y,
    input  logic [COORD_BITS-1:0]        box_w,
    input  logic [COORD_BITS-1:0]        box_h,
    input  logic [2:0]                   dir,

    output logic                         done,
    output logic [31:0]                  focused_id,
    output logic                         focus_valid,
    output logic                         focus_changed,
    output logic [CW-1:0]                entries_used,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic        wrap_enable_reg;
    logic [3:0]  perp_weight_reg;
    logic        cfg_wr;
    dfs_ctl_t    ctl;
    dfs_status_t stat;

    // Configuration registers: written in the APB access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_enable_reg <= 1'b0;
            perp_weight_reg <= PERP_WEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_WRAP_ENABLE: wrap_enable_reg <= pwdata[0];
                REG_PERP_WEIGHT: perp_weight_reg <= pwdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WRAP_ENABLE: prdata = {31'b0, wrap_enable_reg};
            REG_PERP_WEIGHT: prdata = {28'b0, perp_weight_reg};
            default:         prdata = '0;
        endcase
    end

    // Sequencer: steps a move through lookup, scoring and wrap passes.
    dfs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .wrap_enable (wrap_enable_reg),
        .stat        (stat),
        .ctl         (ctl),
        .busy        (busy),
        .done        (done)
    );

    // Entry table, focus state and the scoring pipeline.
    dfs_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cmd           (cmd),
        .elem_id       (elem_id),
        .box_x         (box_x),
        .box_y         (box_y),
        .box_w         (box_w),
        .box_h         (box_h),
        .dir           (dir),
        .perp_weight   (perp_weight_reg),
        .focused_id    (focused_id),
        .focus_valid   (focus_valid),
        .focus_changed (focus_changed),
        .entries_used  (entries_used)
    );

endmodule
